// File: sv/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int ACT_W    = 2;
	localparam int STAT_W   = 2;
	localparam int OCC_W    = 5;

	localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
	localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} spq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the request that is transferred in
		logic exec;   // apply the captured request and load the result
	} spq_cmd_t;

endpackage

// File: sv/sorted_priority_queue.sv
// The controller captures a request when it transfers in and applies it to the sorted
// register array in the S_EXEC state, once the result register is free; the result is
// registered, so it becomes valid when the request is applied. The queue takes no new
// request until the captured one has been applied.
// A waiting result does not block the next input transfer, but that request is applied
// only once the result register is free. Reset clears the entry count and the controller.
module sorted_priority_queue import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [DATA_W-1:0] value_in,
	input  logic signed [DATA_W-1:0] priority_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] value_out,
	output logic [STAT_W-1:0]        status,
	output logic [OCC_W-1:0]         occupancy
);

	// Command bundle from the controller to the datapath.
	spq_cmd_t cmd;

	// The controller sequences each request: it accepts one transfer when idle,
	// then applies it once the result register can take the new result.
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// The datapath keeps the entries sorted with the highest priority in slot zero.
	// A push compares every valid slot against the new priority in parallel and
	// shifts the lower part down by one; a pop shifts every slot up by one.
	spq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (action),
		.value_in    (value_in),
		.priority_in (priority_in),
		.value_out   (value_out),
		.status      (status),
		.occupancy   (occupancy)
	);

	// The queue never reports more entries than it can hold.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= OCC_W'(CAPACITY)))
		else $error("occupancy exceeds capacity");

	// An empty status always comes with the empty marker and no entries.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (value_out == EMPTY_VALUE && occupancy == '0))
		else $error("empty result is inconsistent");

	// A rejected push reports a full queue and returns zero.
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |->
			(value_out == '0 && occupancy == OCC_W'(CAPACITY)))
		else $error("full result is inconsistent");

	// Only one request is in flight: after an input transfer the input stalls.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second request accepted while one is in flight");

endmodule

// File: sv/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output spq_cmd_t cmd
);

	spq_state_t state_q;
	spq_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	// The result register is free when empty or when its transfer completes now.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/spq_dp.sv
// Datapath of the sorted priority queue: sorted entry array and result register.
module spq_dp import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_cmd_t                 cmd,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [DATA_W-1:0] value_in,
	input  logic signed [DATA_W-1:0] priority_in,
	output logic signed [DATA_W-1:0] value_out,
	output logic [STAT_W-1:0]        status,
	output logic [OCC_W-1:0]         occupancy
);

	logic [ACT_W-1:0]         act_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] pri_q;

	logic signed [DATA_W-1:0] ent_val_q [CAPACITY];
	logic signed [DATA_W-1:0] ent_pri_q [CAPACITY];
	logic signed [DATA_W-1:0] ent_val_d [CAPACITY];
	logic signed [DATA_W-1:0] ent_pri_d [CAPACITY];
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;

	logic signed [DATA_W-1:0] res_val_d;
	logic [STAT_W-1:0]        res_stat_d;
	logic signed [DATA_W-1:0] res_val_q;
	logic [STAT_W-1:0]        res_stat_q;
	logic [OCC_W-1:0]         res_occ_q;

	logic [CAPACITY-1:0]      gt;
	logic                     full;
	logic                     empty;

	assign full  = (count_q >= CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// Valid slots holding a strictly higher priority stay in place on a push.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (CNT_W'(i) < count_q) && (ent_pri_q[i] > pri_q);
		end
	end

	always_comb begin
		ent_val_d  = ent_val_q;
		ent_pri_d  = ent_pri_q;
		count_d    = count_q;
		res_val_d  = '0;
		res_stat_d = ST_OK;
		case (act_q)
			ACT_PUSH: begin
				if (full) begin
					res_stat_d = ST_FULL;
				end else begin
					if (!gt[0]) begin
						ent_val_d[0] = val_q;
						ent_pri_d[0] = pri_q;
					end
					for (int i = 1; i < CAPACITY; i++) begin
						if (!gt[i]) begin
							if (gt[i-1]) begin
								ent_val_d[i] = val_q;
								ent_pri_d[i] = pri_q;
							end else begin
								ent_val_d[i] = ent_val_q[i-1];
								ent_pri_d[i] = ent_pri_q[i-1];
							end
						end
					end
					count_d = count_q + 1'b1;
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (empty) begin
					res_val_d  = EMPTY_VALUE;
					res_stat_d = ST_EMPTY;
				end else begin
					res_val_d = ent_val_q[0];
					if (act_q == ACT_POP) begin
						for (int i = 0; i < CAPACITY - 1; i++) begin
							ent_val_d[i] = ent_val_q[i+1];
							ent_pri_d[i] = ent_pri_q[i+1];
						end
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
				res_stat_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			val_q <= value_in;
			pri_q <= priority_in;
		end
		if (cmd.exec) begin
			ent_val_q  <= ent_val_d;
			ent_pri_q  <= ent_pri_d;
			res_val_q  <= res_val_d;
			res_stat_q <= res_stat_d;
			res_occ_q  <= OCC_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	assign value_out = res_val_q;
	assign status    = res_stat_q;
	assign occupancy = res_occ_q;

endmodule
